// ===== rtl/core/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked every clock, skipped while reset is high
`define GCP_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked every clock, reset included
`define GCP_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/gcp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gcp_pkg;

  // configuration port
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam int PIXEL_W = 32;

  // register index, taken from paddr[2]
  localparam logic REG_FADE_ALPHA   = 1'b0;
  localparam logic REG_PIXEL_FORMAT = 1'b1;

  // pixel format codes
  localparam logic FMT_XRGB8888 = 1'b0;
  localparam logic FMT_RGB565   = 1'b1;

  localparam logic [7:0] ALPHA_RESET = 8'hff;

  // luma weights in thousandths
  localparam logic [9:0] COEF_R = 10'd299;
  localparam logic [9:0] COEF_G = 10'd587;
  localparam logic [9:0] COEF_B = 10'd114;

  // floor(x / 1000) = (x * LUMA_RECIP) >> LUMA_SHIFT for x below 2^18
  localparam int LUMA_SHIFT = 28;
  localparam logic [18:0] LUMA_RECIP = 19'd268436;

  // default depth of the request queues
  localparam int QUEUE_DEPTH = 2;

  // live configuration seen by the datapath
  typedef struct packed {
    logic [7:0] alpha;
    logic       fmt;
  } gcp_cfg_t;

  // classified request passed from front to back
  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] luma;
  } gcp_item_t;

endpackage

`default_nettype wire

// ===== rtl/core/grayscale_crossfade_pixel_core.sv =====
// channel   direction  handshake           payload
// pixel in  in         push / full         pixel_in[31:0]
// pixel out out        empty / pop         pixel_out[31:0]
// config    in/out     psel/penable/pready paddr[2:0], pwdata, prdata
//
// one pixel per clock sustained while full is low; a pushed request goes
// through two front stages, request queue, one back stage and result queue
// rst clears all valids, both queues, fade_alpha to 0xff and format to xRGB8888
// full rises only when the last front stage holds a request and the request
// queue is full; a stalled back end fills the queue before the front stops

`timescale 1ns / 1ps
`default_nettype none

module grayscale_crossfade_pixel_core #(
  parameter int QUEUE_DEPTH = gcp_pkg::QUEUE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic [gcp_pkg::PIXEL_W-1:0] pixel_in,
  output logic                        empty,
  input  logic                        pop,
  output logic [gcp_pkg::PIXEL_W-1:0] pixel_out,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gcp_pkg::ADDR_W-1:0]  paddr,
  input  logic [gcp_pkg::DATA_W-1:0]  pwdata,
  output logic [gcp_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  import gcp_pkg::*;

  logic       fade_alpha;
  logic [7:0] fade_alpha_reg;
  logic       pixel_format;
  gcp_cfg_t   cfg;
  logic       cfg_write;
  logic       front_ready;
  logic       front_valid;
  gcp_item_t  front_item;
  logic       mid_full;
  logic       mid_empty;
  logic [$bits(gcp_item_t)-1:0] mid_rdata;
  gcp_item_t  mid_item;
  logic       back_pop;
  logic       back_write;
  logic [PIXEL_W-1:0] back_pixel;
  logic       out_full;

  // register write decode
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign fade_alpha = (paddr[2] == REG_FADE_ALPHA);

  always_ff @(posedge clk) begin
    if (rst) begin
      fade_alpha_reg <= ALPHA_RESET;
      pixel_format   <= FMT_XRGB8888;
    end else if (cfg_write) begin
      if (fade_alpha) begin
        fade_alpha_reg <= pwdata[7:0];
      end else begin
        pixel_format <= pwdata[0];
      end
    end
  end

  // register read
  always_comb begin
    if (fade_alpha) begin
      prdata = {24'b0, fade_alpha_reg};
    end else begin
      prdata = {31'b0, pixel_format};
    end
  end

  assign cfg.alpha = fade_alpha_reg;
  assign cfg.fmt   = pixel_format;

  assign full = !front_ready;

  // front: expand channels, compute luma
  gcp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (push),
    .in_pixel  (pixel_in),
    .in_ready  (front_ready),
    .out_valid (front_valid),
    .out_item  (front_item),
    .out_full  (mid_full)
  );

  // request queue between front and back
  gcp_fifo #(
    .WIDTH ($bits(gcp_item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .wr_en (front_valid),
    .wdata (front_item),
    .full  (mid_full),
    .rd_en (back_pop),
    .rdata (mid_rdata),
    .empty (mid_empty)
  );

  assign mid_item = gcp_item_t'(mid_rdata);

  // back: crossfade toward the original and pack
  gcp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (!mid_empty),
    .in_item   (mid_item),
    .in_pop    (back_pop),
    .out_write (back_write),
    .out_pixel (back_pixel),
    .out_full  (out_full)
  );

  // result queue
  gcp_fifo #(
    .WIDTH (PIXEL_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .wr_en (back_write),
    .wdata (back_pixel),
    .full  (out_full),
    .rd_en (pop),
    .rdata (pixel_out),
    .empty (empty)
  );

endmodule

`default_nettype wire

// ===== rtl/core/gcp_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gcp_fifo #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;
  assign rdata = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/gcp_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gcp_front (
  input  logic                 clk,
  input  logic                 rst,
  input  gcp_pkg::gcp_cfg_t    cfg,
  input  logic                 in_valid,
  input  logic [31:0]          in_pixel,
  output logic                 in_ready,
  output logic                 out_valid,
  output gcp_pkg::gcp_item_t   out_item,
  input  logic                 out_full
);

  import gcp_pkg::*;

  logic       en;
  logic [7:0] r0;
  logic [7:0] g0;
  logic [7:0] b0;
  logic [17:0] sum0;
  logic        v1;
  logic [7:0]  r1;
  logic [7:0]  g1;
  logic [7:0]  b1;
  logic [17:0] sum1;
  logic [36:0] prod1;
  logic        v2;
  gcp_item_t   item2;

  // whole front moves together unless its last stage is blocked
  assign en        = !v2 || !out_full;
  assign in_ready  = en;
  assign out_valid = v2;
  assign out_item  = item2;

  // channel expansion
  always_comb begin
    if (cfg.fmt == FMT_RGB565) begin
      r0 = {in_pixel[15:11], in_pixel[15:13]};
      g0 = {in_pixel[10:5], in_pixel[10:9]};
      b0 = {in_pixel[4:0], in_pixel[4:2]};
    end else begin
      r0 = in_pixel[23:16];
      g0 = in_pixel[15:8];
      b0 = in_pixel[7:0];
    end
  end

  // weighted sum, at most 255000
  assign sum0 = ({8'b0, COEF_R} * {10'b0, r0})
              + ({8'b0, COEF_G} * {10'b0, g0})
              + ({8'b0, COEF_B} * {10'b0, b0});

  // divide by 1000 through the reciprocal
  assign prod1 = {19'b0, sum1} * {18'b0, LUMA_RECIP};

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      r1         <= r0;
      g1         <= g0;
      b1         <= b0;
      sum1       <= sum0;
      item2.r    <= r1;
      item2.g    <= g1;
      item2.b    <= b1;
      item2.luma <= prod1[LUMA_SHIFT +: 8];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/gcp_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gcp_back (
  input  logic                 clk,
  input  logic                 rst,
  input  gcp_pkg::gcp_cfg_t    cfg,
  input  logic                 in_valid,
  input  gcp_pkg::gcp_item_t   in_item,
  output logic                 in_pop,
  output logic                 out_write,
  output logic [31:0]          out_pixel,
  input  logic                 out_full
);

  import gcp_pkg::*;

  // (s - g) * alpha + 0x80 as an 18-bit signed value
  function automatic logic signed [17:0] weigh(input logic [7:0] s,
                                               input logic [7:0] g,
                                               input logic [7:0] alpha);
    logic signed [8:0]  d;
    logic signed [17:0] d18;
    logic signed [17:0] a18;
    d   = $signed({1'b0, s}) - $signed({1'b0, g});
    d18 = 18'(d);
    a18 = $signed({10'b0, alpha});
    return d18 * a18 + 18'sd128;
  endfunction

  // rounded divide by 255, add gray, clamp
  function automatic logic [7:0] blend(input logic signed [17:0] t,
                                       input logic [7:0] g);
    logic signed [17:0] u;
    logic signed [9:0]  m;
    logic signed [10:0] v;
    u = t + (t >>> 8);
    m = 10'(u >>> 8);
    v = $signed({3'b000, g}) + 11'(m);
    if (v < 0) begin
      return 8'd0;
    end else if (v > 11'sd255) begin
      return 8'd255;
    end else begin
      return v[7:0];
    end
  endfunction

  logic               en;
  logic [7:0]         gr0;
  logic [7:0]         gg0;
  logic [7:0]         gb0;
  logic               v1;
  logic signed [17:0] tr1;
  logic signed [17:0] tg1;
  logic signed [17:0] tb1;
  logic [7:0]         gr1;
  logic [7:0]         gg1;
  logic [7:0]         gb1;
  logic [7:0]         r2;
  logic [7:0]         g2;
  logic [7:0]         b2;

  assign en        = !v1 || !out_full;
  assign in_pop    = in_valid && en;
  assign out_write = v1 && !out_full;

  // gray level per channel, 565 round trip of the masked luma
  always_comb begin
    if (cfg.fmt == FMT_RGB565) begin
      gr0 = {in_item.luma[7:3], in_item.luma[7:5]};
      gg0 = {in_item.luma[7:3], 1'b0, in_item.luma[7:6]};
      gb0 = {in_item.luma[7:3], in_item.luma[7:5]};
    end else begin
      gr0 = in_item.luma;
      gg0 = in_item.luma;
      gb0 = in_item.luma;
    end
  end

  // multiply stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_pop;
    end
  end

  // multiply stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      tr1 <= weigh(in_item.r, gr0, cfg.alpha);
      tg1 <= weigh(in_item.g, gg0, cfg.alpha);
      tb1 <= weigh(in_item.b, gb0, cfg.alpha);
      gr1 <= gr0;
      gg1 <= gg0;
      gb1 <= gb0;
    end
  end

  // finish channels and pack
  always_comb begin
    r2 = blend(tr1, gr1);
    g2 = blend(tg1, gg1);
    b2 = blend(tb1, gb1);
    if (cfg.fmt == FMT_RGB565) begin
      out_pixel = {16'b0, r2[7:3], g2[7:2], b2[7:3]};
    end else begin
      out_pixel = {8'hff, r2, g2, b2};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/gcp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module gcp_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        empty,
  input logic                        pop,
  input logic [gcp_pkg::PIXEL_W-1:0] pixel_out,
  input logic                        psel,
  input logic [gcp_pkg::ADDR_W-1:0]  paddr,
  input logic [gcp_pkg::DATA_W-1:0]  prdata
);

  import gcp_pkg::*;

  // no result can come out sooner than the pipeline allows after reset
  `GCP_ASSERT_ALWAYS(a_reset_drain, clk, rst |=> empty ##1 empty ##1 empty ##1 empty, "result too early after reset")

  // a waiting result holds until popped
  `GCP_ASSERT(a_hold, clk, rst, (!empty && !pop) |=> (!empty && $stable(pixel_out)), "result changed while waiting")

  // every result is either a 565 word or carries an opaque alpha byte
  `GCP_ASSERT(a_packing, clk, rst, !empty |-> (pixel_out[31:24] == 8'hff || pixel_out[31:16] == 16'h0000), "bad pixel packing")

  // format register reads back a single bit
  `GCP_ASSERT(a_fmt_read, clk, rst, (psel && paddr[2] == REG_PIXEL_FORMAT) |-> (prdata[31:1] == 31'b0), "format register read has stray bits")

endmodule

bind grayscale_crossfade_pixel_core gcp_checker u_gcp_checker (.*);

`default_nettype wire

// ===== dv/tb_grayscale_crossfade_pixel_core.sv =====
`timescale 1ns / 1ps

module tb_grayscale_crossfade_pixel_core;
  import gcp_pkg::*;

  // expected blended pixels, worked out from each accepted request
  class crossfade_scoreboard;
    logic [7:0]  alpha;
    logic        fmt;
    logic [31:0] blended_q[$];
    int          mismatches;
    int          checked;

    function new();
      alpha = ALPHA_RESET;
      fmt = FMT_XRGB8888;
      mismatches = 0;
      checked = 0;
    endfunction

    function int pending();
      return blended_q.size();
    endfunction

    // rounded divide-by-255 weighting of a signed channel difference
    function int weigh(int diff);
      int w;
      int t;
      w = alpha;
      t = diff * w + 128;
      return (t + (t >>> 8)) >>> 8;
    endfunction

    // 565 channels widened to 8 bits by bit replication
    function void expand565(input logic [15:0] p, output int r, output int g, output int b);
      r = {p[15:11], p[15:13]};
      g = {p[10:5], p[10:9]};
      b = {p[4:0], p[4:2]};
    endfunction

    function logic [15:0] pack565(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      return {r[7:3], g[7:2], b[7:3]};
    endfunction

    function int luma(int r, int g, int b);
      return (299 * r + 587 * g + 114 * b) / 1000;
    endfunction

    function logic [31:0] blend(logic [31:0] p);
      int src_r, src_g, src_b;
      int gray_r, gray_g, gray_b;
      int y;
      logic [7:0] r, g, b;
      if (fmt == FMT_RGB565) begin
        // gray is the masked luma sent through 565 and back
        expand565(p[15:0], src_r, src_g, src_b);
        y = luma(src_r, src_g, src_b) & 'hf8;
        expand565(pack565(y[7:0], y[7:0], y[7:0]), gray_r, gray_g, gray_b);
      end else begin
        src_r = p[23:16];
        src_g = p[15:8];
        src_b = p[7:0];
        y = luma(src_r, src_g, src_b);
        gray_r = y;
        gray_g = y;
        gray_b = y;
      end
      r = 8'(weigh(src_r - gray_r) + gray_r);
      g = 8'(weigh(src_g - gray_g) + gray_g);
      b = 8'(weigh(src_b - gray_b) + gray_b);
      if (fmt == FMT_RGB565)
        return {16'h0000, pack565(r, g, b)};
      return {8'hff, r, g, b};
    endfunction

    function void note_pixel(logic [31:0] p);
      blended_q.push_back(blend(p));
    endfunction

    function void check_pixel(logic [31:0] got);
      logic [31:0] want;
      if (blended_q.size() == 0) begin
        mismatches++;
        $display("%0t: pixel_out expected no request outstanding actual %h", $time, got);
        return;
      end
      want = blended_q.pop_front();
      checked++;
      if (got !== want) begin
        mismatches++;
        $display("%0t: pixel_out expected %h actual %h", $time, want, got);
      end
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                push;
  logic                full;
  logic [PIXEL_W-1:0]  pixel_in;
  logic                empty;
  logic                pop;
  logic [PIXEL_W-1:0]  pixel_out;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  crossfade_scoreboard fade_sb;
  logic no_gaps;
  int   pop_hold;
  int   pixels_sent;
  int   settings_run;
  int   reg_writes;

  grayscale_crossfade_pixel_core dut (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .pixel_in (pixel_in),
    .empty    (empty),
    .pop      (pop),
    .pixel_out(pixel_out),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // mostly short gaps, a few long ones, none while no_gaps is set
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55)
      return 0;
    if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // pixels with saturated channels show up often
  function automatic logic [31:0] rand_pixel();
    logic [31:0] p;
    p = $urandom();
    if ($urandom_range(0, 7) == 0) begin
      for (int i = 0; i < 4; i++) begin
        case ($urandom_range(0, 2))
          0: p[8*i +: 8] = 8'h00;
          1: p[8*i +: 8] = 8'hff;
          default: ;
        endcase
      end
    end
    return p;
  endfunction

  // corner pixels: channel extremes, ignored high bits, pure primaries
  function automatic logic [31:0] corner_pixel(int i);
    case (i)
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      2: return 32'h00ff_0000;
      3: return 32'h0000_ff00;
      4: return 32'h0000_00ff;
      5: return 32'h5a12_3456;
      6: return 32'h0000_0000;
      7: return 32'h0000_ffff;
      8: return 32'h0000_f800;
      9: return 32'h0000_07e0;
      10: return 32'h0000_001f;
      11: return 32'hffff_0000;
      default: return 32'h1234_aa55;
    endcase
  endfunction

  // result side: pop with random stalls
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (pop_hold > 0) begin
      pop <= 1'b0;
      pop_hold--;
    end else begin
      pop <= 1'b1;
      pop_hold = pick_gap();
    end
  end

  // check each popped pixel
  always @(posedge clk) begin
    if (!rst && pop && !empty)
      fade_sb.check_pixel(pixel_out);
  end

  // one request, then a random gap
  task automatic feed_pixel(logic [31:0] p);
    int gap;
    @(negedge clk);
    push <= 1'b1;
    pixel_in <= p;
    do @(posedge clk); while (full);
    fade_sb.note_pixel(p);
    pixels_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // stop pushing and wait for the pipeline to empty out
  task automatic settle();
    @(negedge clk);
    push <= 1'b0;
    while (fade_sb.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // write a register with junk above its width, then read it back
  task automatic write_reg(logic idx, logic [31:0] value);
    logic [31:0] mask;
    logic [31:0] got;
    mask = (idx == REG_FADE_ALPHA) ? 32'h0000_00ff : 32'h0000_0001;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= (value & mask) | ($urandom() & ~mask);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_FADE_ALPHA)
      fade_sb.alpha = value[7:0];
    else
      fade_sb.fmt = value[0];
    reg_writes++;
    // readback
    @(negedge clk);
    psel <= 1'b1;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if ((got & mask) !== (value & mask)) begin
      fade_sb.mismatches++;
      $display("%0t: register %0d readback expected %h actual %h", $time, idx,
               value & mask, got & mask);
    end
  endtask

  // stimulus
  initial begin
    logic [7:0] alpha;
    logic       fmt;
    fade_sb = new();
    no_gaps = 1'b0;
    pop_hold = 0;
    pixels_sent = 0;
    settings_run = 1;
    reg_writes = 0;
    rst = 1'b1;
    push = 1'b0;
    pixel_in = '0;
    pop = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // corners under the reset settings, then in 565 at a mid weight
    for (int i = 0; i < 7; i++)
      feed_pixel(corner_pixel(i));
    settle();
    write_reg(REG_FADE_ALPHA, 32'd100);
    write_reg(REG_PIXEL_FORMAT, {31'h0, FMT_RGB565});
    settings_run++;
    for (int i = 7; i < 13; i++)
      feed_pixel(corner_pixel(i));

    // random phases; weight extremes first, format alternates
    for (int ph = 0; ph < 12; ph++) begin
      settle();
      case (ph)
        0, 1: alpha = 8'd0;
        2, 3: alpha = 8'd255;
        4: alpha = 8'd1;
        5: alpha = 8'd254;
        default: alpha = 8'($urandom_range(0, 255));
      endcase
      fmt = (ph % 2 == 0) ? FMT_XRGB8888 : FMT_RGB565;
      no_gaps = (ph % 4 == 3);
      write_reg(REG_FADE_ALPHA, {24'h0, alpha});
      write_reg(REG_PIXEL_FORMAT, {31'h0, fmt});
      settings_run++;
      repeat (130) feed_pixel(rand_pixel());
    end
    no_gaps = 1'b0;
    settle();
    repeat (10) @(posedge clk);

    $display("covered %0d pixels under %0d weight/format settings in both pixel formats",
             pixels_sent, settings_run);
    $display("%0d pixels checked, %0d register writes read back", fade_sb.checked, reg_writes);
    if (fade_sb.mismatches == 0 && fade_sb.pending() == 0)
      $display("grayscale_crossfade_pixel_core: match");
    else
      $display("grayscale_crossfade_pixel_core: mismatch");
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("timeout with %0d pixels outstanding", fade_sb.pending());
    $display("grayscale_crossfade_pixel_core: mismatch");
    $finish;
  end

endmodule
